/* rtl/sit_pkg.sv */
// ----------------------------------------------------------------------------
// sit_pkg
// Shared widths, register indices and structs of the interval timer block.
// ----------------------------------------------------------------------------
`default_nettype none

package sit_pkg;

  localparam int ELAPSED_W    = 50;
  localparam int SEG_W        = 32;
  localparam int CYC_W        = 34;
  localparam int ITER_W       = 16;
  localparam int PH_W         = 2;
  localparam int USED_W       = 3;
  localparam int MODE_W       = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 50;
  localparam int SEG_SLOTS_DEF = 4;

  // register indices
  localparam logic [CFG_IDX_W-1:0] REG_SEG0      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEGS_USED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ADJUST    = 3'd7;

  // repeat modes
  localparam logic [MODE_W-1:0] MODE_ONCE    = 2'd0;

  // settings derived from the configuration registers
  typedef struct packed {
    logic                 valid;
    logic                 finite;
    logic                 cyc_zero;
    logic                 ext;
    logic [PH_W-1:0]      n_m1;
    logic [ITER_W-1:0]    iter_total;
    logic [ITER_W-1:0]    iter_last;
    logic [CYC_W-1:0]     cycle;
    logic [ELAPSED_W-1:0] base;
    logic [ELAPSED_W-1:0] total;
    logic [SEG_W-1:0]     last_seg;
  } cfg_t;

  typedef struct packed {
    logic                 result_valid;
    logic                 is_done;
    logic                 runs_forever;
    logic [ELAPSED_W-1:0] reported_elapsed;
    logic [ELAPSED_W-1:0] cycle_length;
    logic [ELAPSED_W-1:0] total_length;
    logic [ELAPSED_W-1:0] total_left;
    logic [ITER_W-1:0]    iteration_total;
    logic [ITER_W-1:0]    iteration_now;
    logic [PH_W-1:0]      phase_now;
    logic [SEG_W-1:0]     phase_left;
    logic [CYC_W-1:0]     cycle_offset;
  } res_t;

endpackage

`default_nettype wire

/* rtl/sit_if.sv */
// ----------------------------------------------------------------------------
// sit_if
// Query and result channels of the interval timer block.
// ----------------------------------------------------------------------------
`default_nettype none

interface sit_in_if import sit_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ELAPSED_W-1:0] elapsed_time;
  modport source (output valid, output elapsed_time, input ready);
  modport sink   (input valid, input elapsed_time, output ready);
endinterface

interface sit_out_if import sit_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 result_valid;
  logic                 is_done;
  logic                 runs_forever;
  logic [ELAPSED_W-1:0] reported_elapsed;
  logic [ELAPSED_W-1:0] cycle_length;
  logic [ELAPSED_W-1:0] total_length;
  logic [ELAPSED_W-1:0] total_left;
  logic [ITER_W-1:0]    iteration_total;
  logic [ITER_W-1:0]    iteration_now;
  logic [PH_W-1:0]      phase_now;
  logic [SEG_W-1:0]     phase_left;
  logic [CYC_W-1:0]     cycle_offset;
  modport source (output valid, output result_valid, output is_done, output runs_forever,
                  output reported_elapsed, output cycle_length, output total_length,
                  output total_left, output iteration_total, output iteration_now,
                  output phase_now, output phase_left, output cycle_offset, input ready);
  modport sink   (input valid, input result_valid, input is_done, input runs_forever,
                  input reported_elapsed, input cycle_length, input total_length,
                  input total_left, input iteration_total, input iteration_now,
                  input phase_now, input phase_left, input cycle_offset, output ready);
endinterface

`default_nettype wire

/* rtl/sit_cfg.sv */
// ----------------------------------------------------------------------------
// sit_cfg
// Configuration registers and the timer settings derived from them.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_cfg import sit_pkg::*; #(
  parameter int SEG_SLOTS = SEG_SLOTS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o,
  output logic [CYC_W-1:0]           prefix_o [SEG_SLOTS]
);

  logic [SEG_W-1:0]     seg_q [SEG_SLOTS];
  logic [USED_W-1:0]    used_q;
  logic [MODE_W-1:0]    mode_q;
  logic [ITER_W-1:0]    limit_q;
  logic [ELAPSED_W-1:0] adjust_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SEG_SLOTS; k++) seg_q[k] <= '0;
      used_q   <= '0;
      mode_q   <= '0;
      limit_q  <= '0;
      adjust_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SEGS_USED: used_q   <= cfg_data_i[USED_W-1:0];
        REG_MODE:      mode_q   <= cfg_data_i[MODE_W-1:0];
        REG_LIMIT:     limit_q  <= cfg_data_i[ITER_W-1:0];
        REG_ADJUST:    adjust_q <= cfg_data_i[ELAPSED_W-1:0];
        default: begin
          for (int k = 0; k < SEG_SLOTS; k++) begin
            if (cfg_idx_i == REG_SEG0 + CFG_IDX_W'(k)) seg_q[k] <= cfg_data_i[SEG_W-1:0];
          end
        end
      endcase
    end
  end

  // first step: segment sums and mode decode
  logic [USED_W-1:0] n;
  logic [CYC_W-1:0]  prefix_d [SEG_SLOTS];
  logic [CYC_W-1:0]  cycle_d;
  logic [SEG_W-1:0]  last_seg_d;
  logic              repeat_d, finite_d;
  logic [ITER_W-1:0] iter_total_d;

  always_comb begin
    logic [CYC_W-1:0] acc;
    acc = '0;
    n = (used_q > USED_W'(SEG_SLOTS)) ? USED_W'(SEG_SLOTS) : used_q;
    cycle_d = '0;
    last_seg_d = '0;
    for (int k = 0; k < SEG_SLOTS; k++) begin
      acc = acc + CYC_W'(seg_q[k]);
      prefix_d[k] = acc;
      if (n == USED_W'(k + 1)) begin
        cycle_d    = acc;
        last_seg_d = seg_q[k];
      end
    end
    repeat_d     = (mode_q != MODE_ONCE);
    finite_d     = !repeat_d || (mode_q[1] && (limit_q != '0));
    iter_total_d = repeat_d ? limit_q : ITER_W'(1);
  end

  logic [CYC_W-1:0]     prefix_q [SEG_SLOTS];
  logic [CYC_W-1:0]     cycle_q;
  logic [SEG_W-1:0]     last_seg_q;
  logic                 valid_q, finite_q, repeat_q;
  logic [PH_W-1:0]      n_m1_q;
  logic [ITER_W-1:0]    iter_total_q;
  logic [ELAPSED_W-1:0] base_q, total_q;
  logic                 ext_q;
  logic [ELAPSED_W-1:0] base_d, total_d, red;
  logic [ELAPSED_W:0]   sum;
  logic [ELAPSED_W+ITER_W-1:0] prod;

  // second step: base total; third: adjusted total; fourth: extension flag
  assign prod   = (ELAPSED_W+ITER_W)'(cycle_q) * (ELAPSED_W+ITER_W)'(limit_q);
  assign base_d = !finite_q ? '0 :
                  !repeat_q ? ELAPSED_W'(cycle_q) :
                  (|prod[ELAPSED_W+ITER_W-1:ELAPSED_W]) ? '1 : prod[ELAPSED_W-1:0];
  assign red    = '0 - adjust_q;
  assign sum    = {1'b0, base_q} + {1'b0, adjust_q};
  assign total_d = adjust_q[ELAPSED_W-1] ? ((red >= base_q) ? '0 : base_q - red) :
                   (sum[ELAPSED_W] ? '1 : sum[ELAPSED_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SEG_SLOTS; k++) prefix_q[k] <= '0;
      cycle_q      <= '0;
      last_seg_q   <= '0;
      valid_q      <= 1'b0;
      finite_q     <= 1'b0;
      repeat_q     <= 1'b0;
      n_m1_q       <= '0;
      iter_total_q <= '0;
      base_q       <= '0;
      total_q      <= '0;
      ext_q        <= 1'b0;
    end else begin
      for (int k = 0; k < SEG_SLOTS; k++) prefix_q[k] <= prefix_d[k];
      cycle_q      <= cycle_d;
      last_seg_q   <= last_seg_d;
      valid_q      <= (n != '0);
      finite_q     <= finite_d;
      repeat_q     <= repeat_d;
      n_m1_q       <= PH_W'(n - USED_W'(1));
      iter_total_q <= iter_total_d;
      base_q       <= base_d;
      total_q      <= total_d;
      ext_q        <= (total_q > base_q);
    end
  end

  always_comb begin
    cfg_o.valid      = valid_q;
    cfg_o.finite     = finite_q;
    cfg_o.cyc_zero   = (cycle_q == '0);
    cfg_o.ext        = ext_q;
    cfg_o.n_m1       = n_m1_q;
    cfg_o.iter_total = iter_total_q;
    cfg_o.iter_last  = (iter_total_q != '0) ? iter_total_q - ITER_W'(1) : '0;
    cfg_o.cycle      = cycle_q;
    cfg_o.base       = base_q;
    cfg_o.total      = total_q;
    cfg_o.last_seg   = last_seg_q;
  end

  assign prefix_o = prefix_q;

endmodule

`default_nettype wire

/* rtl/sit_div.sv */
// ----------------------------------------------------------------------------
// sit_div
// Pipelined restoring divider: one quotient bit per stage, elapsed by cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_div import sit_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic [ELAPSED_W-1:0] elapsed_i,
  input  wire logic [CYC_W-1:0]     divisor_i,
  output logic                      valid_o,
  output logic [ELAPSED_W-1:0]      elapsed_o,
  output logic [CYC_W-1:0]          rem_o,
  output logic [ELAPSED_W-1:0]      quo_o
);

  localparam int STAGES = ELAPSED_W;

  logic                 v_q   [STAGES+1];
  logic [ELAPSED_W-1:0] el_q  [STAGES+1];
  logic [CYC_W-1:0]     rem_q [STAGES+1];
  logic [ELAPSED_W-1:0] quo_q [STAGES+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= STAGES; s++) v_q[s] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int s = 0; s < STAGES; s++) v_q[s+1] <= v_q[s];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      el_q[0]  <= elapsed_i;
      rem_q[0] <= '0;
      quo_q[0] <= '0;
    end
  end

  for (genvar s = 0; s < STAGES; s++) begin : g_step
    logic [CYC_W:0] trial;
    logic           take;
    assign trial = {rem_q[s], el_q[s][STAGES-1-s]};
    assign take  = (trial >= {1'b0, divisor_i});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        el_q[s+1]  <= el_q[s];
        rem_q[s+1] <= take ? CYC_W'(trial - {1'b0, divisor_i}) : CYC_W'(trial);
        quo_q[s+1] <= {quo_q[s][ELAPSED_W-2:0], take};
      end
    end
  end

  assign valid_o   = v_q[STAGES];
  assign elapsed_o = el_q[STAGES];
  assign rem_o     = rem_q[STAGES];
  assign quo_o     = quo_q[STAGES];

endmodule

`default_nettype wire

/* rtl/sit_fmt.sv */
// ----------------------------------------------------------------------------
// sit_fmt
// Phase search and result assembly for one divided query.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_fmt import sit_pkg::*; #(
  parameter int SEG_SLOTS = SEG_SLOTS_DEF
) (
  input  wire logic [ELAPSED_W-1:0] elapsed_i,
  input  wire logic [CYC_W-1:0]     rem_i,
  input  wire logic [ELAPSED_W-1:0] quo_i,
  input  wire cfg_t                 cfg_i,
  input  wire logic [CYC_W-1:0]     prefix_i [SEG_SLOTS],
  output res_t                      res_o
);

  always_comb begin
    logic                 found;
    logic [PH_W-1:0]      phase;
    logic [SEG_W-1:0]     pleft;
    logic [CYC_W-1:0]     diff;
    logic [ELAPSED_W-1:0] left;
    found = 1'b0;
    phase = cfg_i.n_m1;
    pleft = cfg_i.last_seg;
    diff  = '0;
    left  = cfg_i.total - elapsed_i;
    for (int k = 0; k < SEG_SLOTS; k++) begin
      if (!found && (PH_W'(k) <= cfg_i.n_m1) && (rem_i < prefix_i[k])) begin
        found = 1'b1;
        phase = PH_W'(k);
        diff  = prefix_i[k] - rem_i;
        pleft = diff[SEG_W-1:0];
      end
    end

    res_o = '0;
    if (cfg_i.valid) begin
      res_o.result_valid     = 1'b1;
      res_o.runs_forever     = !cfg_i.finite;
      res_o.reported_elapsed = elapsed_i;
      res_o.cycle_length     = ELAPSED_W'(cfg_i.cycle);
      res_o.total_length     = cfg_i.total;
      if (!cfg_i.cyc_zero) begin
        res_o.iteration_total = cfg_i.iter_total;
        if (cfg_i.finite && (elapsed_i >= cfg_i.total)) begin
          res_o.is_done          = 1'b1;
          res_o.reported_elapsed = cfg_i.total;
          res_o.iteration_now    = cfg_i.iter_last;
          res_o.phase_now        = cfg_i.n_m1;
        end else if (cfg_i.finite && (elapsed_i >= cfg_i.base) && cfg_i.ext) begin
          // running into the extension: hold the last phase
          res_o.total_left    = left;
          res_o.iteration_now = cfg_i.iter_last;
          res_o.phase_now     = cfg_i.n_m1;
          res_o.phase_left    = (|left[ELAPSED_W-1:SEG_W]) ? '1 : left[SEG_W-1:0];
          res_o.cycle_offset  = cfg_i.cycle;
        end else begin
          res_o.iteration_now = (|quo_i[ELAPSED_W-1:ITER_W]) ? '1 : quo_i[ITER_W-1:0];
          res_o.cycle_offset  = rem_i;
          res_o.phase_now     = phase;
          res_o.phase_left    = pleft;
          res_o.total_left    = cfg_i.finite ? left : '0;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/segmented_interval_timer_position_top.sv */
// ----------------------------------------------------------------------------
// segmented_interval_timer_position_top
// Reports where a programmed multi-segment interval timer stands at a given
// elapsed time: completion, iteration, phase and time left.
// ----------------------------------------------------------------------------
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+-----------------------------------------
//   in_i     | in  | valid / ready | elapsed_time
//   out_o    | out | valid / ready | result_valid .. cycle_offset (12 fields)
//   cfg_*_i  | in  | write enable  | cfg_idx_i selects register, cfg_data_i
//
// One transaction enters per cycle while the output does not stall; each
// query passes the divider, which resolves one quotient bit per stage, and
// then the output register. Derived settings settle in registered steps
// after a configuration write, the cycle length for the divider first.
// Reset is asynchronous and active low; it clears the configuration and
// settings registers and all stage valid bits. A stall at the output
// freezes every stage together, so nothing is dropped or duplicated.
// ----------------------------------------------------------------------------
`default_nettype none

module segmented_interval_timer_position_top import sit_pkg::*; #(
  parameter int SEG_SLOTS = SEG_SLOTS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  sit_in_if.sink                     in_i,
  sit_out_if.source                  out_o
);

  cfg_t             cfg;
  logic [CYC_W-1:0] prefix [SEG_SLOTS];

  sit_cfg #(.SEG_SLOTS(SEG_SLOTS)) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .prefix_o   (prefix)
  );

  // advance the whole pipe whenever the output register can move
  logic out_v_q;
  res_t out_q;
  logic en;
  assign en         = !out_v_q || out_o.ready;
  assign in_i.ready = en;

  logic                 div_v;
  logic [ELAPSED_W-1:0] div_el, div_quo;
  logic [CYC_W-1:0]     div_rem;

  sit_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_i.valid),
    .elapsed_i (in_i.elapsed_time),
    .divisor_i (cfg.cycle),
    .valid_o   (div_v),
    .elapsed_o (div_el),
    .rem_o     (div_rem),
    .quo_o     (div_quo)
  );

  res_t res;

  sit_fmt #(.SEG_SLOTS(SEG_SLOTS)) u_fmt (
    .elapsed_i (div_el),
    .rem_i     (div_rem),
    .quo_i     (div_quo),
    .cfg_i     (cfg),
    .prefix_i  (prefix),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= div_v;
    end
  end

  // hold the result while the sink stalls
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res;
    end
  end

  assign out_o.valid            = out_v_q;
  assign out_o.result_valid     = out_q.result_valid;
  assign out_o.is_done          = out_q.is_done;
  assign out_o.runs_forever     = out_q.runs_forever;
  assign out_o.reported_elapsed = out_q.reported_elapsed;
  assign out_o.cycle_length     = out_q.cycle_length;
  assign out_o.total_length     = out_q.total_length;
  assign out_o.total_left       = out_q.total_left;
  assign out_o.iteration_total  = out_q.iteration_total;
  assign out_o.iteration_now    = out_q.iteration_now;
  assign out_o.phase_now        = out_q.phase_now;
  assign out_o.phase_left       = out_q.phase_left;
  assign out_o.cycle_offset     = out_q.cycle_offset;

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_q.result_valid) |->
      (!out_q.is_done && !out_q.runs_forever && out_q.total_length == '0))
    else $error("invalid result carries nonzero fields");

  a_done_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.is_done) |->
      (out_q.total_left == '0 && out_q.reported_elapsed == out_q.total_length
       && !out_q.runs_forever))
    else $error("done result not clamped to total");

  a_offset_in_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.result_valid && !out_q.is_done) |->
      (ELAPSED_W'(out_q.cycle_offset) <= out_q.cycle_length))
    else $error("cycle offset beyond cycle length");

endmodule

`default_nettype wire
